>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> rtl/dwsm_pkg.sv
// Package: types and constants of the wheel speed meter.
`timescale 1ns / 1ps

package dwsm_pkg;

    localparam int NUM_LANES   = 2;
    localparam int TIMER_BITS  = 16;
    localparam int CNT_BITS    = 6;
    localparam int SPEED_BITS  = 16;
    localparam int SCALE_BITS  = 32;
    localparam int TOTAL_BITS  = CNT_BITS + TIMER_BITS;
    localparam int STEP_BITS   = $clog2(SCALE_BITS);
    localparam int FILT_BITS   = SPEED_BITS + 3;
    localparam int PROD_BITS   = 2 * FILT_BITS;
    localparam int RECIP_SHIFT = 21;
    // ceil(2^21 / 5): exact floor(x/5) for every x below 2^19
    localparam logic [FILT_BITS-1:0] RECIP5 = FILT_BITS'(419431);

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = SCALE_BITS;

    localparam logic [SCALE_BITS-1:0] SCALE_RESET   = 32'd720000000;
    localparam logic [SPEED_BITS-1:0] LIMIT_RESET   = 16'd20000;
    localparam logic [CNT_BITS-1:0]   TIMEOUT_RESET = 6'd10;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SPEED_SCALE       = 2'd0,
        REG_SPEED_LIMIT       = 2'd1,
        REG_TIMEOUT_OVERFLOWS = 2'd2
    } t_reg_idx;

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } t_top_state;

    typedef enum logic [1:0] {
        L_IDLE,
        L_DIV,
        L_MUL,
        L_DONE
    } t_lane_state;

    typedef struct packed {
        logic [SCALE_BITS-1:0] scale;
        logic [SPEED_BITS-1:0] limit;
        logic [CNT_BITS-1:0]   timeout;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic ack;
    } t_lane_ctl;

    typedef struct packed {
        logic                  fin;
        logic [SPEED_BITS-1:0] speed;
        logic                  updated;
    } t_lane_stat;

endpackage

>>> rtl/dwsm_if.sv
// Handshake channel interfaces for interrupt items and speed results.
`timescale 1ns / 1ps

interface dwsm_in_if;
    logic        valid;
    logic        ready;
    logic        overflow_event;
    logic        left_capture_event;
    logic [15:0] left_capture_time;
    logic        right_capture_event;
    logic [15:0] right_capture_time;

    modport source (
        output valid, overflow_event, left_capture_event, left_capture_time,
               right_capture_event, right_capture_time,
        input  ready
    );
    modport sink (
        input  valid, overflow_event, left_capture_event, left_capture_time,
               right_capture_event, right_capture_time,
        output ready
    );
endinterface

interface dwsm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] left_speed;
    logic        left_updated;
    logic [15:0] right_speed;
    logic        right_updated;

    modport source (
        output valid, left_speed, left_updated, right_speed, right_updated,
        input  ready
    );
    modport sink (
        input  valid, left_speed, left_updated, right_speed, right_updated,
        output ready
    );
endinterface

>>> rtl/dwsm_div.sv
// Restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module dwsm_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [dwsm_pkg::SCALE_BITS-1:0]     i_dividend,
    input  logic [dwsm_pkg::TOTAL_BITS-1:0]     i_divisor,
    output logic                                o_done,
    output logic [dwsm_pkg::SCALE_BITS-1:0]     o_quot
);

    logic                                r_busy;
    logic                                r_done;
    logic [dwsm_pkg::STEP_BITS-1:0]      r_step;
    logic [dwsm_pkg::SCALE_BITS-1:0]     r_q;
    logic [dwsm_pkg::TOTAL_BITS-1:0]     r_rem;
    logic [dwsm_pkg::TOTAL_BITS-1:0]     r_div;

    logic [dwsm_pkg::TOTAL_BITS:0]       w_rem_sh;
    logic [dwsm_pkg::TOTAL_BITS:0]       w_diff;
    logic                                w_ge;
    logic [dwsm_pkg::TOTAL_BITS-1:0]     n_rem;

    always_comb begin
        w_rem_sh = {r_rem, r_q[dwsm_pkg::SCALE_BITS-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_div});
        w_diff   = w_rem_sh - {1'b0, r_div};
        n_rem    = w_ge ? w_diff[dwsm_pkg::TOTAL_BITS-1:0]
                        : w_rem_sh[dwsm_pkg::TOTAL_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == '1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[dwsm_pkg::SCALE_BITS-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

>>> rtl/dwsm_lane.sv
// One wheel lane: edge capture, period, speed division and IIR filter.
`timescale 1ns / 1ps

module dwsm_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dwsm_pkg::t_lane_ctl                 i_ctl,
    input  dwsm_pkg::t_cfg                      i_cfg,
    input  logic                                i_ovf,
    input  logic                                i_cap,
    input  logic [dwsm_pkg::TIMER_BITS-1:0]     i_time,
    output dwsm_pkg::t_lane_stat                o_stat
);

    dwsm_pkg::t_lane_state               r_state;
    dwsm_pkg::t_lane_state               n_state;

    logic                                r_armed;
    logic                                r_done;
    logic [dwsm_pkg::CNT_BITS-1:0]       r_cnt;
    logic [dwsm_pkg::TIMER_BITS-1:0]     r_per;
    logic [dwsm_pkg::SPEED_BITS-1:0]     r_filt;
    logic                                r_upd;
    logic [dwsm_pkg::PROD_BITS-1:0]      r_prod;

    logic                                e_armed;
    logic                                e_done;
    logic [dwsm_pkg::CNT_BITS-1:0]       e_cnt;
    logic [dwsm_pkg::TIMER_BITS-1:0]     e_per;

    logic [dwsm_pkg::TOTAL_BITS-1:0]     w_total;
    logic                                w_div_start;
    logic                                w_div_done;
    logic [dwsm_pkg::SCALE_BITS-1:0]     w_quot;
    logic                                w_accept;
    logic [dwsm_pkg::FILT_BITS-1:0]      w_blend;

    assign w_total = {r_cnt, r_per};

    // Event update for a lane that has no finished measurement
    always_comb begin
        e_armed = r_armed;
        e_done  = r_done;
        e_cnt   = r_cnt;
        e_per   = r_per;
        if (i_ovf && r_armed) begin
            if (r_cnt >= i_cfg.timeout) begin
                e_done = 1'b1;
                e_per  = '1;
            end else begin
                e_cnt = r_cnt + 1'b1;
            end
        end
        if (i_cap) begin
            if (r_armed) begin
                if ((i_time < e_per) && (e_cnt != '0)) begin
                    e_cnt = e_cnt - 1'b1;
                end
                e_per  = i_time - e_per;
                e_done = 1'b1;
            end else begin
                e_cnt   = '0;
                e_per   = i_time;
                e_armed = 1'b1;
            end
        end
    end

    assign w_accept = (w_quot < {{(dwsm_pkg::SCALE_BITS-dwsm_pkg::SPEED_BITS){1'b0}},
                                  i_cfg.limit});
    assign w_blend  = {1'b0, w_quot[dwsm_pkg::SPEED_BITS-1:0], 2'b00}
                    + {3'b000, r_filt};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dwsm_pkg::L_IDLE: begin
                if (i_ctl.start) begin
                    n_state = (r_done && (w_total != '0)) ? dwsm_pkg::L_DIV
                                                           : dwsm_pkg::L_DONE;
                end
            end
            dwsm_pkg::L_DIV: begin
                if (w_div_done) begin
                    n_state = w_accept ? dwsm_pkg::L_MUL : dwsm_pkg::L_DONE;
                end
            end
            dwsm_pkg::L_MUL: begin
                n_state = dwsm_pkg::L_DONE;
            end
            dwsm_pkg::L_DONE: begin
                if (i_ctl.ack) begin
                    n_state = dwsm_pkg::L_IDLE;
                end
            end
            default: n_state = dwsm_pkg::L_IDLE;
        endcase
    end

    always_comb begin
        w_div_start    = (r_state == dwsm_pkg::L_IDLE) && i_ctl.start
                       && r_done && (w_total != '0);
        o_stat.fin     = (r_state == dwsm_pkg::L_DONE);
        o_stat.speed   = r_filt;
        o_stat.updated = r_upd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dwsm_pkg::L_IDLE;
            r_armed <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_per   <= '0;
            r_filt  <= '0;
            r_upd   <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == dwsm_pkg::L_IDLE) && i_ctl.start) begin
                r_upd <= 1'b0;
                if (r_done) begin
                    // finished measurement is consumed, flags of this item ignored
                    r_armed <= 1'b0;
                    r_done  <= 1'b0;
                    r_cnt   <= '0;
                end else begin
                    r_armed <= e_armed;
                    r_done  <= e_done;
                    r_cnt   <= e_cnt;
                    r_per   <= e_per;
                end
            end
            if (r_state == dwsm_pkg::L_MUL) begin
                r_filt <= r_prod[dwsm_pkg::RECIP_SHIFT+dwsm_pkg::SPEED_BITS-1:
                                 dwsm_pkg::RECIP_SHIFT];
                r_upd  <= 1'b1;
            end
        end
    end

    // floor(x/5) by reciprocal multiply
    always_ff @(posedge i_clk) begin
        if ((r_state == dwsm_pkg::L_DIV) && w_div_done) begin
            r_prod <= w_blend * dwsm_pkg::RECIP5;
        end
    end

    dwsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_cfg.scale),
        .i_divisor  (w_total),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

endmodule

>>> rtl/dual_wheel_period_speed_meter_unit.sv
// Top level: dual wheel speed meter with two parallel measurement lanes.
`timescale 1ns / 1ps
//
// Usage
//  - i_in carries one timer interrupt per transaction: the shared overflow flag
//    plus capture flag and 16-bit timestamp for each wheel.
//  - o_out returns exactly one transaction per input: both filtered speeds and
//    a flag per wheel saying whether that speed was rewritten on this item.
//  - i_cfg_we / i_cfg_idx / i_cfg_data write speed_scale (0), speed_limit (1)
//    and timeout_overflows (2); other indexes are ignored. Write only when idle.
// Timing
//  - One item in flight. Without a finished measurement the lanes go
//    straight to done and the result is loaded once the output register
//    is free. A speed calculation runs 32 restoring divider steps in each
//    lane, then the x/5 filter multiply, the filtered speed write, the load.
//  - Both lanes run side by side; the result is merged when both are finished.
// Reset
//  - Synchronous, active low. Lanes disarmed, speeds zero, registers at their
//    defaults. No clearing pass is needed.
// Back-pressure
//  - The result sits in an output register; a new item is accepted while it
//    waits. Finished lane results hold until the output register is free.
`include "assert_macros.svh"

module dual_wheel_period_speed_meter_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    dwsm_in_if.sink                                i_in,
    dwsm_out_if.source                             o_out,
    input  logic                                   i_cfg_we,
    input  logic [dwsm_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [dwsm_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);

    // ---------------- configuration registers ----------------
    dwsm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale   <= dwsm_pkg::SCALE_RESET;
            r_cfg.limit   <= dwsm_pkg::LIMIT_RESET;
            r_cfg.timeout <= dwsm_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (dwsm_pkg::t_reg_idx'(i_cfg_idx))
                dwsm_pkg::REG_SPEED_SCALE:
                    r_cfg.scale <= i_cfg_data;
                dwsm_pkg::REG_SPEED_LIMIT:
                    r_cfg.limit <= i_cfg_data[dwsm_pkg::SPEED_BITS-1:0];
                dwsm_pkg::REG_TIMEOUT_OVERFLOWS:
                    r_cfg.timeout <= i_cfg_data[dwsm_pkg::CNT_BITS-1:0];
                default: ;  // unused index: write dropped
            endcase
        end
    end

    // ---------------- sequencer ----------------
    dwsm_pkg::t_top_state r_state;
    dwsm_pkg::t_top_state n_state;

    logic                                  w_in_acc;
    logic                                  w_load;
    logic                                  w_all_fin;
    logic                                  w_any_fin;
    logic [dwsm_pkg::NUM_LANES-1:0]        w_fin;
    dwsm_pkg::t_lane_ctl                   w_ctl;
    dwsm_pkg::t_lane_stat                  w_stat [dwsm_pkg::NUM_LANES];

    logic                                  w_cap  [dwsm_pkg::NUM_LANES];
    logic [dwsm_pkg::TIMER_BITS-1:0]       w_time [dwsm_pkg::NUM_LANES];

    logic                                  r_out_valid;
    logic [dwsm_pkg::SPEED_BITS-1:0]       r_left_speed;
    logic                                  r_left_updated;
    logic [dwsm_pkg::SPEED_BITS-1:0]       r_right_speed;
    logic                                  r_right_updated;

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_all_fin = &w_fin;
    assign w_any_fin = |w_fin;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dwsm_pkg::S_IDLE: if (w_in_acc) n_state = dwsm_pkg::S_BUSY;
            dwsm_pkg::S_BUSY: if (w_load)   n_state = dwsm_pkg::S_IDLE;
            default:          n_state = dwsm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = (r_state == dwsm_pkg::S_IDLE);
        w_load     = (r_state == dwsm_pkg::S_BUSY) && w_all_fin
                   && (!r_out_valid || o_out.ready);
        w_ctl.start = w_in_acc;
        w_ctl.ack   = w_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dwsm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- lanes: 0 = left, 1 = right ----------------
    assign w_cap[0]  = i_in.left_capture_event;
    assign w_time[0] = i_in.left_capture_time;
    assign w_cap[1]  = i_in.right_capture_event;
    assign w_time[1] = i_in.right_capture_time;

    for (genvar k = 0; k < dwsm_pkg::NUM_LANES; k++) begin : g_lane
        dwsm_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_cfg   (r_cfg),
            .i_ovf   (i_in.overflow_event),
            .i_cap   (w_cap[k]),
            .i_time  (w_time[k]),
            .o_stat  (w_stat[k])
        );
        assign w_fin[k] = w_stat[k].fin;
    end

    // ---------------- merge into output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_left_speed    <= w_stat[0].speed;
            r_left_updated  <= w_stat[0].updated;
            r_right_speed   <= w_stat[1].speed;
            r_right_updated <= w_stat[1].updated;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.left_speed    = r_left_speed;
    assign o_out.left_updated  = r_left_updated;
    assign o_out.right_speed   = r_right_speed;
    assign o_out.right_updated = r_right_updated;

    // ---------------- assertions ----------------
    `ASSERT_PROP(a_acc_busy, i_clk, i_rst_n, w_in_acc |=> (r_state == dwsm_pkg::S_BUSY), "accepted transaction did not start work")
    `ASSERT_PROP(a_load_fin, i_clk, i_rst_n, $rose(o_out.valid) |-> $past(w_all_fin), "result loaded before all lanes finished")
    `ASSERT_NEVER(a_idle_fin, i_clk, i_rst_n, (r_state == dwsm_pkg::S_IDLE) && w_any_fin, "lane holds a result while sequencer idle")

endmodule

>>> tb/tb_dual_wheel_period_speed_meter_unit.sv
// Testbench: dual wheel speed meter, directed and random interrupts checked against a predictor.
`timescale 1ns / 1ps

module tb_dual_wheel_period_speed_meter_unit;

    // Hard stop, well clear of the slowest legal run (about 1300 transactions,
    // each up to a full divide plus long random stalls on both sides).
    localparam int unsigned CYCLE_LIMIT = 1000000;
    // Settle beyond the longest item latency, a full divide plus filter and load.
    localparam int          DRAIN_CYCLES = 50;
    // Cap on printed mismatch lines; every mismatch is still counted.
    localparam int          MAX_PRINTS   = 100;

    // One timer interrupt as offered on the input channel.
    typedef struct packed {
        logic        ovf;
        logic        l_cap;
        logic [15:0] l_time;
        logic        r_cap;
        logic [15:0] r_time;
    } t_irq;

    // One speed report as returned on the output channel.
    typedef struct packed {
        logic [15:0] l_speed;
        logic        l_upd;
        logic [15:0] r_speed;
        logic        r_upd;
    } t_speeds;

    logic i_clk;
    logic i_rst_n;
    logic                               cfg_we;
    logic [dwsm_pkg::CFG_IDX_BITS-1:0]  cfg_idx;
    logic [dwsm_pkg::CFG_DATA_BITS-1:0] cfg_data;

    dwsm_in_if  in_if ();
    dwsm_out_if out_if ();

    dual_wheel_period_speed_meter_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Stimulus and scoreboard storage.
    t_irq    irq_q[$];         // interrupts waiting to be offered
    t_speeds speed_q[$];       // predicted speed reports, oldest first

    int          src_idle_pct;
    int          snk_idle_pct;
    logic        in_taken;
    int          n_errors;
    int unsigned n_cycles;

    // Predictor copy of the registers.
    logic [dwsm_pkg::SCALE_BITS-1:0] k_scale;
    logic [dwsm_pkg::SPEED_BITS-1:0] k_limit;
    logic [dwsm_pkg::CNT_BITS-1:0]   k_timeout;

    // Predictor copy of the per-wheel state: index 0 is left, 1 is right.
    logic                            wh_armed  [dwsm_pkg::NUM_LANES];
    logic                            wh_done   [dwsm_pkg::NUM_LANES];
    logic [dwsm_pkg::CNT_BITS-1:0]   wh_ovf_cnt[dwsm_pkg::NUM_LANES];
    // start time when armed, period when done
    logic [dwsm_pkg::TIMER_BITS-1:0] wh_mark   [dwsm_pkg::NUM_LANES];
    logic [dwsm_pkg::SPEED_BITS-1:0] wh_speed  [dwsm_pkg::NUM_LANES];

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor: advance one wheel by one interrupt, return the update flag.
    // ------------------------------------------------------------------
    function automatic logic wheel_step(int k, logic ovf, logic cap, logic [15:0] t);
        logic [dwsm_pkg::TOTAL_BITS-1:0] ticks;
        logic [dwsm_pkg::SCALE_BITS-1:0] quo;
        logic [dwsm_pkg::TIMER_BITS-1:0] first;
        logic                            wrote;
        wrote = 1'b0;
        // A finished measurement is turned into a speed on the next interrupt;
        // the flags of this wheel on that interrupt are ignored.
        if (wh_done[k]) begin
            ticks = {wh_ovf_cnt[k], wh_mark[k]};
            if (ticks != '0) begin
                quo = k_scale / dwsm_pkg::SCALE_BITS'(ticks);
                // glitch filter, then blend 4/5 new + 1/5 old
                if (quo < dwsm_pkg::SCALE_BITS'(k_limit)) begin
                    wh_speed[k] = 16'((4 * quo + 32'(wh_speed[k])) / 5);
                    wrote = 1'b1;
                end
            end
            wh_armed[k]   = 1'b0;
            wh_done[k]    = 1'b0;
            wh_ovf_cnt[k] = '0;
            return wrote;
        end
        // Overflow while armed: count it, or time out at the configured count.
        if (ovf && wh_armed[k]) begin
            if (wh_ovf_cnt[k] >= k_timeout) begin
                wh_done[k] = 1'b1;
                wh_mark[k] = '1;
            end else begin
                wh_ovf_cnt[k] = wh_ovf_cnt[k] + 1'b1;
            end
        end
        if (cap) begin
            if (wh_armed[k]) begin
                // second edge: wrapped difference, wrap takes one overflow back
                first      = wh_mark[k];
                wh_mark[k] = t - first;
                if (t < first && wh_ovf_cnt[k] != '0)
                    wh_ovf_cnt[k] = wh_ovf_cnt[k] - 1'b1;
                wh_done[k] = 1'b1;
            end else begin
                wh_ovf_cnt[k] = '0;
                wh_mark[k]    = t;
                wh_armed[k]   = 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // One line per mismatch, counted; printing stops after MAX_PRINTS lines.
    task automatic report_mismatch(string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("tb: mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Input driver: offers queued interrupts at the falling edge, idling at
    // random; a transaction is held until the rising edge accepts it.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_irq nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            if (irq_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt = irq_q.pop_front();
                in_if.overflow_event      <= nxt.ovf;
                in_if.left_capture_event  <= nxt.l_cap;
                in_if.left_capture_time   <= nxt.l_time;
                in_if.right_capture_event <= nxt.r_cap;
                in_if.right_capture_time  <= nxt.r_time;
                in_if.valid               <= 1'b1;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random back-pressure, held off during reset.
    always @(negedge i_clk) begin
        out_if.ready <= i_rst_n && ($urandom_range(99) >= snk_idle_pct);
    end

    // Input monitor: every accepted interrupt goes through the predictor.
    always @(posedge i_clk) begin
        t_speeds want;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            want.l_upd   = wheel_step(0, in_if.overflow_event, in_if.left_capture_event,
                                      in_if.left_capture_time);
            want.l_speed = wh_speed[0];
            want.r_upd   = wheel_step(1, in_if.overflow_event, in_if.right_capture_event,
                                      in_if.right_capture_time);
            want.r_speed = wh_speed[1];
            speed_q.push_back(want);
        end
        in_taken <= i_rst_n && in_if.valid && in_if.ready;
    end

    // Output monitor: each accepted report against the oldest prediction.
    always @(posedge i_clk) begin
        t_speeds want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (speed_q.size() == 0) begin
                report_mismatch("speed report with no interrupt outstanding");
            end else begin
                want = speed_q.pop_front();
                check_field("left_speed",    out_if.left_speed,    want.l_speed);
                check_field("left_updated",  out_if.left_updated,  want.l_upd);
                check_field("right_speed",   out_if.right_speed,   want.r_speed);
                check_field("right_updated", out_if.right_updated, want.r_upd);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_irq(logic ovf, logic lc, logic [15:0] lt,
                                     logic rc, logic [15:0] rt);
        t_irq it;
        it.ovf    = ovf;
        it.l_cap  = lc;
        it.l_time = lt;
        it.r_cap  = rc;
        it.r_time = rt;
        irq_q.push_back(it);
    endfunction

    // Register write at the falling edge; the predictor copy follows at once,
    // which is safe as nothing is in flight while registers change.
    task automatic write_reg(dwsm_pkg::t_reg_idx idx,
                             logic [dwsm_pkg::CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            dwsm_pkg::REG_SPEED_SCALE:       k_scale   = data;
            dwsm_pkg::REG_SPEED_LIMIT:       k_limit   = data[dwsm_pkg::SPEED_BITS-1:0];
            dwsm_pkg::REG_TIMEOUT_OVERFLOWS: k_timeout = data[dwsm_pkg::CNT_BITS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Block until every queued interrupt is accepted and every report is in.
    // Checked at the rising edge, where the driver's valid is settled.
    task automatic wait_drained();
        while (irq_q.size() != 0 || in_if.valid || speed_q.size() != 0)
            @(posedge i_clk);
    endtask

    // One random phase: new register values, new idling, then n interrupts.
    // Overflow and capture odds are per phase so that some phases build long
    // overflow runs (timeouts) and others complete measurements quickly.
    task automatic run_phase(logic [31:0] scale, logic [15:0] limit, logic [5:0] tmo,
                             int p_ovf, int p_cap, int src_idle, int snk_idle, int n);
        wait_drained();
        repeat (4) @(negedge i_clk);
        write_reg(dwsm_pkg::REG_SPEED_SCALE, scale);
        write_reg(dwsm_pkg::REG_SPEED_LIMIT, 32'(limit));
        write_reg(dwsm_pkg::REG_TIMEOUT_OVERFLOWS, 32'(tmo));
        src_idle_pct = src_idle;
        snk_idle_pct = snk_idle;
        for (int i = 0; i < n; i++)
            push_irq($urandom_range(99) < p_ovf,
                     $urandom_range(99) < p_cap, 16'($urandom_range(65535)),
                     $urandom_range(99) < p_cap, 16'($urandom_range(65535)));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // all inputs known from time zero
        i_rst_n  = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = dwsm_pkg::REG_SPEED_SCALE;
        cfg_data = '0;
        in_if.valid               = 1'b0;
        in_if.overflow_event      = 1'b0;
        in_if.left_capture_event  = 1'b0;
        in_if.left_capture_time   = '0;
        in_if.right_capture_event = 1'b0;
        in_if.right_capture_time  = '0;
        out_if.ready = 1'b0;
        in_taken     = 1'b0;
        n_errors     = 0;
        n_cycles     = 0;
        src_idle_pct = 26;
        snk_idle_pct = 86;

        // predictor at its reset state
        k_scale   = dwsm_pkg::SCALE_RESET;
        k_limit   = dwsm_pkg::LIMIT_RESET;
        k_timeout = dwsm_pkg::TIMEOUT_RESET;
        for (int k = 0; k < dwsm_pkg::NUM_LANES; k++) begin
            wh_armed[k]   = 1'b0;
            wh_done[k]    = 1'b0;
            wh_ovf_cnt[k] = '0;
            wh_mark[k]    = '0;
            wh_speed[k]   = '0;
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- Directed part, default registers ---
        // arm both wheels at the timer extremes
        push_irq(1'b0, 1'b1, 16'h0000, 1'b1, 16'hFFFF);
        push_irq(1'b1, 1'b0, 16'h0000, 1'b0, 16'h0000);
        // left: full-range period; right: wrapped, count 1 -> 0
        push_irq(1'b0, 1'b1, 16'hFFFF, 1'b1, 16'h0000);
        // done wheels ignore these flags; left accepted, right rejected as glitch
        push_irq(1'b1, 1'b1, 16'h1234, 1'b1, 16'h4321);
        push_irq(1'b0, 1'b1, 16'h8000, 1'b1, 16'h8000);
        // left: zero period, zero divisor; right: wrap with count already zero
        push_irq(1'b0, 1'b1, 16'h8000, 1'b1, 16'h7FFF);
        push_irq(1'b0, 1'b0, 16'h0000, 1'b0, 16'h0000);
        // left re-armed at the top; right idle sees an overflow unarmed
        push_irq(1'b0, 1'b1, 16'hFFFF, 1'b0, 16'h0000);
        push_irq(1'b1, 1'b1, 16'h0005, 1'b0, 16'h0000);
        push_irq(1'b0, 1'b0, 16'h0000, 1'b0, 16'h0000);
        // timeout: ten overflows reach the count, the eleventh times out;
        // the right wheel captures on that same interrupt
        push_irq(1'b0, 1'b1, 16'h1000, 1'b1, 16'h2000);
        repeat (10) push_irq(1'b1, 1'b0, 16'h0000, 1'b0, 16'h0000);
        push_irq(1'b1, 1'b0, 16'h0000, 1'b1, 16'h0100);
        push_irq(1'b0, 1'b0, 16'h0000, 1'b0, 16'h0000);

        // --- Random part ---
        // sender idles lightly, receiver heavily
        run_phase(32'd720000000, 16'd20000, 6'd10, 30, 30, 26, 86, 215);
        run_phase(32'hFFFF_FFFF, 16'hFFFF, 6'd1, 50, 25, 26, 86, 215);
        // roles swapped; rare captures let overflow runs reach the top timeout
        run_phase(32'd1, 16'd1, 6'd63, 90, 2, 86, 26, 215);
        run_phase(32'($urandom_range(32'hFFFF_FFFF, 1)), 16'($urandom_range(65535, 1)),
                  6'($urandom_range(63, 1)), 40, 30, 86, 26, 215);
        // no idling on either side
        run_phase(32'h8000_0000, 16'hFFFF, 6'd3, 35, 35, 0, 0, 215);
        run_phase(32'($urandom_range(32'hFFFF_FFFF, 1)), 16'($urandom_range(65535, 1)),
                  6'($urandom_range(63, 1)), 20, 50, 0, 0, 215);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
